>>> design/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared constants, result codes and the result item type for the deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

   // Default width of the frame length counter.
   localparam int LEN_BITS_DEFAULT = 64;

   // Parser phase codes.
   localparam logic [2:0] PH_HDR0  = 3'd0;
   localparam logic [2:0] PH_HDR1  = 3'd1;
   localparam logic [2:0] PH_EXT16 = 3'd2;
   localparam logic [2:0] PH_EXT64 = 3'd3;
   localparam logic [2:0] PH_MASK  = 3'd4;
   localparam logic [2:0] PH_DATA  = 3'd5;

   // Frame opcodes that the deframer acts on.
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;

   // Seven-bit length codes that announce an extended length.
   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   // Result kinds.
   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_CLOSE = 2'd2;
   localparam logic [1:0] KIND_PING  = 2'd3;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [7:0] data;
      logic       msg_end;
   } rsp_item_type;

endpackage

>>> design/websocket_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// A result goes to the output register, or to the skid entry while that is held.
// Throughput: one request byte per cycle unless req_stall is high; the header parse
// or payload unmask of a byte is done in one pass between state and result registers.
// Reset (synchronous, active high) returns the parser to the first header byte,
// clears the stop flag after a close frame and empties the result buffer.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit #(
   parameter int LEN_BITS = wsfd_pkg::LEN_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // Request channel: received stream bytes.
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   // Response channel: payload bytes and frame events.
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_message_end
);

   // Parser state. The length counter saturates when an extended length
   // does not fit in LEN_BITS bits.
   logic [2:0]          phase_ff, phase_in;
   logic                fin_ff, fin_in;
   logic [3:0]          opcode_ff, opcode_in;
   logic                mask_present_ff, mask_present_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic [2:0]          hdr_cnt_ff, hdr_cnt_in;
   logic [31:0]         mask_key_ff, mask_key_in;
   logic [1:0]          mask_idx_ff, mask_idx_in;
   logic                stopped_ff, stopped_in;

   // Result buffer: an output register plus one skid entry, so the parser
   // keeps taking bytes while a result waits on a stalled receiver.
   wsfd_pkg::rsp_item_type out_ff;
   wsfd_pkg::rsp_item_type skid_ff;
   logic                   out_valid_ff;
   logic                   skid_valid_ff;

   wsfd_pkg::rsp_item_type item;
   logic                   req_accept;
   logic                   rsp_take;
   logic                   go_after_len;
   logic                   go_hdr_done;
   logic [3:0]             hdr_cnt_inc;
   logic [7:0]             key_byte;
   logic [7:0]             rx;

   // Event for a frame whose last byte has just arrived. Only text frames
   // with FIN set, close frames and ping frames report anything.
   function automatic wsfd_pkg::rsp_item_type frame_event(input logic [3:0] op,
                                                          input logic       fin);
      wsfd_pkg::rsp_item_type ev;
      ev = '0;
      if (op == wsfd_pkg::OP_TEXT && fin) begin
         ev.valid   = 1'b1;
         ev.kind    = wsfd_pkg::KIND_END;
         ev.msg_end = 1'b1;
      end else if (op == wsfd_pkg::OP_CLOSE) begin
         ev.valid = 1'b1;
         ev.kind  = wsfd_pkg::KIND_CLOSE;
      end else if (op == wsfd_pkg::OP_PING) begin
         ev.valid = 1'b1;
         ev.kind  = wsfd_pkg::KIND_PING;
      end
      return ev;
   endfunction

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = out_valid_ff && !rsp_stall;
   assign rx         = req_rx_byte;

   assign hdr_cnt_inc = {1'b0, hdr_cnt_ff} + 4'd1;

   // Mask key byte for this payload byte; the first key byte sits on top.
   always_comb begin
      case (mask_idx_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
   end

   // Single-pass parser: one byte updates the header fields or is unmasked.
   always_comb begin
      phase_in        = phase_ff;
      fin_in          = fin_ff;
      opcode_in       = opcode_ff;
      mask_present_in = mask_present_ff;
      len_in          = len_ff;
      hdr_cnt_in      = hdr_cnt_ff;
      mask_key_in     = mask_key_ff;
      mask_idx_in     = mask_idx_ff;
      stopped_in      = stopped_ff;
      item            = '0;
      go_after_len    = 1'b0;
      go_hdr_done     = 1'b0;

      if (req_accept && !stopped_ff) begin
         unique case (phase_ff) inside
            wsfd_pkg::PH_HDR1: begin
               mask_present_in = rx[7];
               hdr_cnt_in      = '0;
               len_in          = '0;
               if (rx[6:0] == wsfd_pkg::LEN7_EXT16) begin
                  phase_in = wsfd_pkg::PH_EXT16;
               end else if (rx[6:0] == wsfd_pkg::LEN7_EXT64) begin
                  phase_in = wsfd_pkg::PH_EXT64;
               end else begin
                  len_in       = LEN_BITS'(rx[6:0]);
                  go_after_len = 1'b1;
               end
            end
            wsfd_pkg::PH_EXT16, wsfd_pkg::PH_EXT64: begin
               // Shift in the next big-endian length byte, saturating when
               // the value would no longer fit.
               if (|len_ff[LEN_BITS-1 -: 8]) begin
                  len_in = '1;
               end else begin
                  len_in = {len_ff[LEN_BITS-9:0], rx};
               end
               hdr_cnt_in = hdr_cnt_inc[2:0];
               if (phase_ff == wsfd_pkg::PH_EXT16) begin
                  go_after_len = (hdr_cnt_inc[2:0] == 3'd2);
               end else begin
                  go_after_len = (hdr_cnt_inc[2:0] == 3'd0);
               end
            end
            wsfd_pkg::PH_MASK: begin
               mask_key_in = {mask_key_ff[23:0], rx};
               hdr_cnt_in  = hdr_cnt_inc[2:0];
               if (hdr_cnt_inc[2:0] == 3'd4) begin
                  hdr_cnt_in  = '0;
                  go_hdr_done = 1'b1;
               end
            end
            wsfd_pkg::PH_DATA: begin
               mask_idx_in = mask_idx_ff + 2'd1;
               len_in      = len_ff - LEN_BITS'(1);
               if (opcode_ff == wsfd_pkg::OP_TEXT) begin
                  item.valid   = 1'b1;
                  item.kind    = wsfd_pkg::KIND_TEXT;
                  item.data    = mask_present_ff ? (rx ^ key_byte) : rx;
                  item.msg_end = (len_in == '0) && fin_ff;
                  if (len_in == '0) begin
                     phase_in = wsfd_pkg::PH_HDR0;
                  end
               end else if (len_in == '0) begin
                  // Last byte of a frame that is not text: report the event.
                  phase_in = wsfd_pkg::PH_HDR0;
                  item     = frame_event(opcode_ff, fin_ff);
               end
            end
            default: begin
               // First header byte; unused phase codes land here too.
               fin_in    = rx[7];
               opcode_in = rx[3:0];
               phase_in  = wsfd_pkg::PH_HDR1;
            end
         endcase

         // Length is known: fetch the mask key, or finish the header.
         if (go_after_len) begin
            hdr_cnt_in = '0;
            if (mask_present_in) begin
               phase_in    = wsfd_pkg::PH_MASK;
               mask_key_in = '0;
            end else begin
               go_hdr_done = 1'b1;
            end
         end

         // Header complete: an empty frame ends right here.
         if (go_hdr_done) begin
            mask_idx_in = '0;
            if (len_in == '0) begin
               phase_in = wsfd_pkg::PH_HDR0;
               item     = frame_event(opcode_ff, fin_ff);
            end else begin
               phase_in = wsfd_pkg::PH_DATA;
            end
         end

         // A close frame halts the parser until reset.
         if (item.valid && item.kind == wsfd_pkg::KIND_CLOSE) begin
            stopped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= wsfd_pkg::PH_HDR0;
         fin_ff          <= 1'b0;
         opcode_ff       <= '0;
         mask_present_ff <= 1'b0;
         len_ff          <= '0;
         hdr_cnt_ff      <= '0;
         mask_key_ff     <= '0;
         mask_idx_ff     <= '0;
         stopped_ff      <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         fin_ff          <= fin_in;
         opcode_ff       <= opcode_in;
         mask_present_ff <= mask_present_in;
         len_ff          <= len_in;
         hdr_cnt_ff      <= hdr_cnt_in;
         mask_key_ff     <= mask_key_in;
         mask_idx_ff     <= mask_idx_in;
         stopped_ff      <= stopped_in;
      end
   end

   // Result buffer. The skid entry only fills while the output register is
   // held; a full skid entry stalls requests, so it is never overwritten.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (rsp_take || !out_valid_ff) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_ff       <= item;
               out_valid_ff <= item.valid;
            end
         end else if (item.valid) begin
            skid_ff       <= item;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_payload_byte = out_ff.data;
   assign rsp_message_end  = out_ff.msg_end;

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Streams received bytes into the deframer and checks every payload byte and
// frame event it returns. A short table of hand-built frames comes first. After
// it come randomized frames mixed with stray bytes under three idling patterns,
// one long binary frame, and a close frame that stops the parser.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int LEN_W = wsfd_pkg::LEN_BITS_DEFAULT;
   localparam logic [LEN_W-1:0] LEN_ALL = '1;
   // Longest run of cycles in which neither channel moves anything.
   localparam int QUIET_LIMIT = 2000;
   // Length of the deliberate receiver hold-off, in cycles.
   localparam int HOLD_CYCLES = 64;

   // One expected result of the deframer.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       msg_end;
   } ws_event_type;

   localparam ws_event_type NO_EVENT = '0;

   // One row of a directed table. When typed is set, the expected result is
   // taken from the row (has_ev says whether one is expected at all) instead
   // of from the predictor.
   typedef struct packed {
      logic [7:0]   rx;
      logic         typed;
      logic         has_ev;
      ws_event_type ev;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_payload_byte;
   logic       rsp_message_end;

   websocket_frame_deframer_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_message_end  (rsp_message_end)
   );

   // Results that the predictor has worked out and the block has not yet
   // returned, oldest first.
   ws_event_type pending_events[$];
   int           mismatch_count = 0;
   int           bytes_sent = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   // Each increment asks the receiver for one long hold-off.
   int           hold_requests = 0;

   // Predictor copy of the parser state.
   logic [2:0]       parse_phase = wsfd_pkg::PH_HDR0;
   logic             frame_fin = 1'b0;
   logic [3:0]       frame_op = 4'h0;
   logic             frame_masked = 1'b0;
   logic [LEN_W-1:0] bytes_left = '0;
   logic [2:0]       hdr_count = 3'd0;
   logic [31:0]      mask_word = 32'h0;
   logic [1:0]       mask_pos = 2'd0;
   logic             parser_halted = 1'b0;

   // Opening table. It covers the empty final and non-final text frames, a
   // masked two-byte text frame with all-ones and all-zeros bytes, a ping
   // whose length arrives in the 64-bit extended form, and an empty
   // continuation frame whose 16-bit extended length is zero.
   stim_row_type opening_rows [27] = '{
      '{8'h81, 1'b0, 1'b0, NO_EVENT},
      '{8'h00, 1'b1, 1'b1, '{wsfd_pkg::KIND_END, 8'h00, 1'b1}},
      '{8'h01, 1'b0, 1'b0, NO_EVENT},
      '{8'h00, 1'b1, 1'b0, NO_EVENT},
      '{8'h81, 1'b0, 1'b0, NO_EVENT},
      '{8'h82, 1'b0, 1'b0, NO_EVENT},
      '{8'hFF, 1'b0, 1'b0, NO_EVENT},
      '{8'h0F, 1'b0, 1'b0, NO_EVENT},
      '{8'hA5, 1'b0, 1'b0, NO_EVENT},
      '{8'h5A, 1'b0, 1'b0, NO_EVENT},
      '{8'h00, 1'b1, 1'b1, '{wsfd_pkg::KIND_TEXT, 8'hFF, 1'b0}},
      '{8'hFF, 1'b1, 1'b1, '{wsfd_pkg::KIND_TEXT, 8'hF0, 1'b1}},
      '{8'h89, 1'b0, 1'b0, NO_EVENT},
      '{8'h7F, 1'b0, 1'b0, NO_EVENT},
      '{8'h00, 1'b0, 1'b0, NO_EVENT},
      '{8'h00, 1'b0, 1'b0, NO_EVENT},
      '{8'h00, 1'b0, 1'b0, NO_EVENT},
      '{8'h00, 1'b0, 1'b0, NO_EVENT},
      '{8'h00, 1'b0, 1'b0, NO_EVENT},
      '{8'h00, 1'b0, 1'b0, NO_EVENT},
      '{8'h00, 1'b0, 1'b0, NO_EVENT},
      '{8'h01, 1'b0, 1'b0, NO_EVENT},
      '{8'h33, 1'b1, 1'b1, '{wsfd_pkg::KIND_PING, 8'h00, 1'b0}},
      '{8'h80, 1'b0, 1'b0, NO_EVENT},
      '{8'h7E, 1'b0, 1'b0, NO_EVENT},
      '{8'h00, 1'b0, 1'b0, NO_EVENT},
      '{8'h00, 1'b1, 1'b0, NO_EVENT}
   };

   // Closing table: an empty masked close frame, then a text frame that the
   // stopped parser must swallow without a result.
   stim_row_type closing_rows [9] = '{
      '{8'h88, 1'b0, 1'b0, NO_EVENT},
      '{8'h80, 1'b0, 1'b0, NO_EVENT},
      '{8'h11, 1'b0, 1'b0, NO_EVENT},
      '{8'h22, 1'b0, 1'b0, NO_EVENT},
      '{8'h33, 1'b0, 1'b0, NO_EVENT},
      '{8'h44, 1'b1, 1'b1, '{wsfd_pkg::KIND_CLOSE, 8'h00, 1'b0}},
      '{8'h81, 1'b1, 1'b0, NO_EVENT},
      '{8'h05, 1'b1, 1'b0, NO_EVENT},
      '{8'h41, 1'b1, 1'b0, NO_EVENT}
   };

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // The last byte of a frame has arrived and it carried no text byte.
   // Close and ping frames report here, as does an empty final text frame.
   function automatic bit frame_complete(output ws_event_type ev);
      ev = NO_EVENT;
      parse_phase = wsfd_pkg::PH_HDR0;
      if (frame_op == wsfd_pkg::OP_TEXT && frame_fin && bytes_left == '0) begin
         ev.kind = wsfd_pkg::KIND_END;
         ev.msg_end = 1'b1;
         return 1'b1;
      end
      if (frame_op == wsfd_pkg::OP_CLOSE) begin
         parser_halted = 1'b1;
         ev.kind = wsfd_pkg::KIND_CLOSE;
         return 1'b1;
      end
      if (frame_op == wsfd_pkg::OP_PING) begin
         ev.kind = wsfd_pkg::KIND_PING;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Header fully parsed: either the frame is already over, or payload follows.
   function automatic bit header_complete(output ws_event_type ev);
      ev = NO_EVENT;
      mask_pos = 2'd0;
      if (bytes_left == '0)
         return frame_complete(ev);
      parse_phase = wsfd_pkg::PH_DATA;
      return 1'b0;
   endfunction

   // Length known: a mask key may still follow.
   function automatic bit length_complete(output ws_event_type ev);
      ev = NO_EVENT;
      hdr_count = 3'd0;
      if (frame_masked) begin
         parse_phase = wsfd_pkg::PH_MASK;
         mask_word = 32'h0;
         return 1'b0;
      end
      return header_complete(ev);
   endfunction

   // Advances the predictor by one received byte. Returns 1 when the byte
   // causes a result, which is then placed in ev.
   function automatic bit deframe_byte(input logic [7:0] b, output ws_event_type ev);
      logic [7:0] plain;
      logic [6:0] len7;
      ev = NO_EVENT;
      if (parser_halted)
         return 1'b0;
      case (parse_phase) inside
         wsfd_pkg::PH_HDR1: begin
            len7 = b[6:0];
            frame_masked = b[7];
            hdr_count = 3'd0;
            bytes_left = '0;
            if (len7 == wsfd_pkg::LEN7_EXT16) begin
               parse_phase = wsfd_pkg::PH_EXT16;
               return 1'b0;
            end
            if (len7 == wsfd_pkg::LEN7_EXT64) begin
               parse_phase = wsfd_pkg::PH_EXT64;
               return 1'b0;
            end
            bytes_left = LEN_W'(len7);
            return length_complete(ev);
         end
         wsfd_pkg::PH_EXT16, wsfd_pkg::PH_EXT64: begin
            // A length wider than the counter pins it at all ones.
            if (bytes_left > (LEN_ALL >> 8))
               bytes_left = LEN_ALL;
            else
               bytes_left = {bytes_left[LEN_W-9:0], b};
            hdr_count = hdr_count + 3'd1;
            if (parse_phase == wsfd_pkg::PH_EXT16 ? hdr_count == 3'd2 : hdr_count == 3'd0)
               return length_complete(ev);
            return 1'b0;
         end
         wsfd_pkg::PH_MASK: begin
            mask_word = {mask_word[23:0], b};
            hdr_count = hdr_count + 3'd1;
            if (hdr_count == 3'd4) begin
               hdr_count = 3'd0;
               return header_complete(ev);
            end
            return 1'b0;
         end
         wsfd_pkg::PH_DATA: begin
            plain = b;
            if (frame_masked)
               plain = b ^ mask_word[8 * (3 - int'(mask_pos)) +: 8];
            mask_pos = mask_pos + 2'd1;
            bytes_left = bytes_left - 1'b1;
            if (frame_op == wsfd_pkg::OP_TEXT) begin
               if (bytes_left == '0)
                  parse_phase = wsfd_pkg::PH_HDR0;
               ev.kind = wsfd_pkg::KIND_TEXT;
               ev.data = plain;
               ev.msg_end = (bytes_left == '0) && frame_fin;
               return 1'b1;
            end
            if (bytes_left == '0)
               return frame_complete(ev);
            return 1'b0;
         end
         default: begin
            // First header byte; unused phase codes land here as well.
            frame_fin = b[7];
            frame_op = b[3:0];
            parse_phase = wsfd_pkg::PH_HDR1;
            return 1'b0;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Clock and stimulus
   // ------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offers one request byte and waits until the block takes it. The call
   // starts and ends at a falling edge, so req_valid stays high between
   // back-to-back requests. Unless raw is set, the byte is shaped so that
   // stray bytes can neither start a close frame (which would stop the parser
   // for the rest of the run) nor announce a length that never ends.
   task automatic send_byte(input logic [7:0] b, input bit raw, input bit typed,
                            input bit typed_hit, input ws_event_type typed_ev);
      ws_event_type ev;
      bit           hit;
      if (!raw && !parser_halted) begin
         if (parse_phase == wsfd_pkg::PH_HDR0 && b[3:0] == wsfd_pkg::OP_CLOSE)
            b[0] = 1'b1;
         if (parse_phase == wsfd_pkg::PH_EXT64 && hdr_count < 3'd6)
            b = 8'h00;
         if ((parse_phase == wsfd_pkg::PH_EXT64 && hdr_count == 3'd6) ||
             (parse_phase == wsfd_pkg::PH_EXT16 && hdr_count == 3'd0))
            b = b & 8'h01;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      hit = deframe_byte(b, ev);
      if (typed) begin
         hit = typed_hit;
         ev = typed_ev;
      end
      if (hit)
         pending_events.insert(pending_events.size(), ev);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_plain(input logic [7:0] b);
      send_byte(b, 1'b0, 1'b0, 1'b0, NO_EVENT);
   endtask

   // One well-formed frame with random header bits, opcode, length form,
   // mask and payload. Close is never chosen here; it ends the run.
   task automatic send_frame(input bit text_only);
      logic [7:0] hdr0;
      logic [3:0] op;
      logic       masked;
      int         pick;
      int         len;
      pick = text_only ? 0 : $urandom_range(99);
      if (pick < 50)
         op = wsfd_pkg::OP_TEXT;
      else if (pick < 65)
         op = wsfd_pkg::OP_PING;
      else if (pick < 73)
         op = 4'h0;
      else if (pick < 81)
         op = 4'h2;
      else if (pick < 88)
         op = 4'hA;
      else begin
         op = 4'($urandom_range(15));
         if (op == wsfd_pkg::OP_CLOSE)
            op = 4'hB;
      end
      hdr0 = 8'($urandom_range(255));
      hdr0[3:0] = op;
      masked = 1'($urandom_range(1));
      send_plain(hdr0);
      pick = $urandom_range(99);
      if (pick < 70) begin
         len = $urandom_range(12);
         send_plain({masked, 7'(len)});
      end else if (pick < 80) begin
         len = $urandom_range(125, 100);
         send_plain({masked, 7'(len)});
      end else if (pick < 90) begin
         len = $urandom_range(300);
         send_plain({masked, wsfd_pkg::LEN7_EXT16});
         send_plain(8'(len >> 8));
         send_plain(8'(len));
      end else begin
         len = $urandom_range(300);
         send_plain({masked, wsfd_pkg::LEN7_EXT64});
         repeat (6) send_plain(8'h00);
         send_plain(8'(len >> 8));
         send_plain(8'(len));
      end
      if (masked)
         repeat (4) send_plain(8'($urandom_range(255)));
      repeat (len) send_plain(8'($urandom_range(255)));
   endtask

   // Random traffic until the given number of further requests has gone in.
   // About one pick in ten is a burst of stray bytes, which knocks the frame
   // boundaries out of line until the parser finds its way back.
   task automatic run_random_traffic(input int count);
      int target;
      target = bytes_sent + count;
      while (bytes_sent < target) begin
         if ($urandom_range(99) < 10)
            repeat ($urandom_range(6, 1)) send_plain(8'($urandom_range(255)));
         else
            send_frame(1'b0);
      end
   endtask

   // Feeds filler until the predictor stands at the start of a frame.
   task automatic align_to_frame();
      while (parse_phase != wsfd_pkg::PH_HDR0)
         send_plain(8'h00);
   endtask

   // The sender stops offering and waits for every expected result.
   task automatic wait_for_all_events();
      req_valid <= 1'b0;
      while (pending_events.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = 8'h00;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase one: sender idles now and then, receiver mostly stalls.
      send_idle_pct = 19;
      recv_idle_pct = 76;
      foreach (opening_rows[i])
         send_byte(opening_rows[i].rx, 1'b0, opening_rows[i].typed,
                   opening_rows[i].has_ev, opening_rows[i].ev);
      run_random_traffic(100);
      wait_for_all_events();

      // Phase two: the roles swap.
      send_idle_pct = 76;
      recv_idle_pct = 19;
      run_random_traffic(100);
      wait_for_all_events();

      // Phase three: nobody idles. The receiver first holds off for a long
      // stretch while a text frame and then random traffic arrive, so the result
      // buffer fills and the block has to stall its request side.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      send_frame(1'b1);
      run_random_traffic(100);

      // A binary frame whose length comes in the 16-bit extended form. Its
      // header bytes go in unshaped; its payload gives no result.
      align_to_frame();
      send_byte(8'h82, 1'b1, 1'b0, 1'b0, NO_EVENT);
      send_byte({1'b0, wsfd_pkg::LEN7_EXT16}, 1'b1, 1'b0, 1'b0, NO_EVENT);
      send_byte(8'h00, 1'b1, 1'b0, 1'b0, NO_EVENT);
      send_byte(8'h80, 1'b1, 1'b0, 1'b0, NO_EVENT);
      repeat (128) send_plain(8'($urandom_range(255)));

      // Close frame last: the parser stops for good after it.
      align_to_frame();
      foreach (closing_rows[i])
         send_byte(closing_rows[i].rx, 1'b1, closing_rows[i].typed,
                   closing_rows[i].has_ev, closing_rows[i].ev);
      wait_for_all_events();

      // Then watch on for any stray result after the last one.
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_events.size() == 0)
         $display("websocket_frame_deframer_unit test passed");
      else
         $display("websocket_frame_deframer_unit test failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Receiver: drives rsp_stall at the falling edge and checks results at the
   // rising edge.
   // ------------------------------------------------------------------------

   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_seen) begin
            hold_left = HOLD_CYCLES;
            hold_seen = hold_requests;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      ws_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d data %02h end %0d",
                                      rsp_kind, rsp_payload_byte, rsp_message_end));
         end else begin
            want = pending_events.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch($sformatf("kind %0d, expected %0d", rsp_kind, want.kind));
            if (rsp_payload_byte !== want.data)
               report_mismatch($sformatf("payload byte %02h, expected %02h",
                                         rsp_payload_byte, want.data));
            if (rsp_message_end !== want.msg_end)
               report_mismatch($sformatf("message end %0d, expected %0d",
                                         rsp_message_end, want.msg_end));
         end
      end
   end

   // Watchdog: ends the run when neither channel has moved for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("websocket_frame_deframer_unit test failed");
      $finish;
   end

endmodule

>>> sim.f
design/wsfd_pkg.sv
design/websocket_frame_deframer_unit.sv
dv/tb_top.sv
